// File: rtl/sha1_pkg.sv
`timescale 1ns / 1ps
package sha1_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Item handed from the front part to the compression engine.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;
  } cmd_t;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [6:0] LAST_ROUND = 7'd79;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] t);
    if (t < 7'd20) round_k = 32'h5A827999;
    else if (t < 7'd40) round_k = 32'h6ED9EBA1;
    else if (t < 7'd60) round_k = 32'h8F1BBCDC;
    else round_k = 32'hCA62C1D6;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    if (t < 7'd20) round_f = (b & c) | (~b & d);
    else if (t >= 7'd40 && t < 7'd60) round_f = (b & c) | (b & d) | (c & d);
    else round_f = b ^ c ^ d;
  endfunction

endpackage

// File: rtl/sha1_queue.sv
`timescale 1ns / 1ps
module sha1_queue #(
  parameter int DEPTH = sha1_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  sha1_pkg::cmd_t   wdata,
  output logic             full,
  input  logic             rd,
  output sha1_pkg::cmd_t   rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha1_pkg::cmd_t mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0] count;

  assign full = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd && !empty) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
    end
  end
endmodule

// File: rtl/sha1_engine.sv
`timescale 1ns / 1ps
module sha1_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  sha1_pkg::cmd_t        cmd,
  input  logic                  cmd_empty,
  output logic                  cmd_pop,
  output sha1_pkg::out_item_t   result,
  output logic                  empty,
  input  logic                  pop
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROUND = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_PAD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state;
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [31:0] w [16];
  logic [5:0] block_fill;
  logic [63:0] message_bits;
  logic [63:0] len_hold;
  logic [6:0] round_count;
  logic padding;
  logic pad_first;
  logic len_phase;
  logic [2:0] out_idx;

  logic [7:0] in_byte;
  logic in_put;
  logic [31:0] w_new;
  logic [31:0] w_cur;
  logic [31:0] tmp;
  logic [3:0] ti;
  logic [5:0] len_sel;

  assign ti = round_count[3:0];
  assign w_new = sha1_pkg::rotl(w[ti - 4'd3] ^ w[ti - 4'd8] ^ w[ti - 4'd14] ^ w[ti], 1);
  assign w_cur = (round_count < 7'd16) ? w[ti] : w_new;
  assign tmp = sha1_pkg::rotl(a, 5) + sha1_pkg::round_f(round_count, b, c, d) + e
               + sha1_pkg::round_k(round_count) + w_cur;

  assign len_sel = 6'd56 - {block_fill[2:0], 3'b000};

  // Byte source: a message byte from the queue, or one padding byte.
  // The length goes only into the block that the padding closes.
  always_comb begin
    in_byte = 8'h00;
    in_put = 1'b0;
    if (state == S_IDLE && !cmd_empty && cmd.has_byte) begin
      in_byte = cmd.data_byte;
      in_put = 1'b1;
    end else if (state == S_PAD) begin
      in_put = 1'b1;
      if (pad_first) in_byte = sha1_pkg::PAD_BYTE;
      else if (len_phase && block_fill >= sha1_pkg::LEN_POS)
        in_byte = 8'(len_hold >> (len_sel));
      else in_byte = 8'h00;
    end
  end

  assign cmd_pop = (state == S_IDLE) && !cmd_empty;
  assign empty = (state != S_OUT);
  assign result.digest_word = h[out_idx];
  assign result.word_index = out_idx;
  assign result.last_word = (out_idx == 3'd4);

  always_ff @(posedge clk) begin
    if (in_put) begin
      if (block_fill[1:0] == 2'd0) w[block_fill[5:2]] <= {in_byte, 24'h0};
      else w[block_fill[5:2]] <= w[block_fill[5:2]]
                                 | ({24'h0, in_byte} << (5'd24 - {block_fill[1:0], 3'b000}));
    end else if (state == S_ROUND) begin
      w[ti] <= w_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      h[0] <= sha1_pkg::H0; h[1] <= sha1_pkg::H1; h[2] <= sha1_pkg::H2;
      h[3] <= sha1_pkg::H3; h[4] <= sha1_pkg::H4;
      a <= '0; b <= '0; c <= '0; d <= '0; e <= '0;
      block_fill <= '0;
      message_bits <= '0;
      len_hold <= '0;
      round_count <= '0;
      padding <= 1'b0;
      pad_first <= 1'b0;
      len_phase <= 1'b0;
      out_idx <= '0;
    end else begin
      if (in_put) begin
        block_fill <= block_fill + 6'd1;
        if (block_fill == 6'd63) begin
          a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
          round_count <= '0;
        end
      end
      case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            if (cmd.has_byte) message_bits <= message_bits + 64'd8;
            if (cmd.last_byte) begin
              len_hold <= message_bits + (cmd.has_byte ? 64'd8 : 64'd0);
              pad_first <= 1'b1;
              padding <= 1'b1;
            end
            if (cmd.has_byte && block_fill == 6'd63) state <= S_ROUND;
            else if (cmd.last_byte) state <= S_PAD;
          end
        end
        S_PAD: begin
          pad_first <= 1'b0;
          // The marker byte leaves room for the length in this same block.
          if (pad_first && block_fill < sha1_pkg::LEN_POS) len_phase <= 1'b1;
          if (block_fill == 6'd63) state <= S_ROUND;
        end
        S_ROUND: begin
          e <= d; d <= c; c <= sha1_pkg::rotl(b, 30); b <= a; a <= tmp;
          round_count <= round_count + 7'd1;
          if (round_count == sha1_pkg::LAST_ROUND) state <= S_ADD;
        end
        S_ADD: begin
          round_count <= '0;
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          // Padding is done once the block that carried the length is compressed.
          if (!padding) state <= S_IDLE;
          else if (len_phase) state <= S_OUT;
          else begin
            len_phase <= 1'b1;
            state <= S_PAD;
          end
        end
        S_OUT: begin
          if (pop) begin
            if (out_idx == 3'd4) begin
              out_idx <= '0;
              state <= S_IDLE;
              padding <= 1'b0;
              len_phase <= 1'b0;
              message_bits <= '0;
              a <= '0; b <= '0; c <= '0; d <= '0; e <= '0;
              h[0] <= sha1_pkg::H0; h[1] <= sha1_pkg::H1; h[2] <= sha1_pkg::H2;
              h[3] <= sha1_pkg::H3; h[4] <= sha1_pkg::H4;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/sha1_message_digest.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake    | Word
// in_item  | input     | push / full  | data_byte, has_byte, last_byte
// out_item | output    | pop / empty  | digest_word, word_index, last_word
//
// Each byte is taken by the engine in its idle state; each 64-byte block then adds
// 80 rounds and one add step in the compression engine. A last byte adds padding
// bytes at one a cycle plus one or two compressions, then five result words.
// Reset is synchronous on rst. The input queue keeps taking items, until it is
// full, while the engine works or waits on pop.
module sha1_message_digest #(
  parameter int QDEPTH = sha1_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sha1_pkg::in_item_t   in_item,
  output logic                 full,
  input  logic                 pop,
  output sha1_pkg::out_item_t  out_item,
  output logic                 empty
);
  sha1_pkg::cmd_t q_in;
  sha1_pkg::cmd_t q_out;
  logic q_empty;
  logic q_pop;

  always_comb begin
    q_in.data_byte = in_item.data_byte;
    q_in.has_byte = in_item.has_byte;
    q_in.last_byte = in_item.last_byte;
  end

  sha1_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst(rst), .wr(push), .wdata(q_in), .full(full),
    .rd(q_pop), .rdata(q_out), .empty(q_empty)
  );

  sha1_engine u_engine (
    .clk(clk), .rst(rst), .cmd(q_out), .cmd_empty(q_empty), .cmd_pop(q_pop),
    .result(out_item), .empty(empty), .pop(pop)
  );

`ifndef ASSERT_OFF
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_item.last_word == (out_item.word_index == 3'd4)))
    else $error("last_word mismatch");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_item.word_index <= 3'd4))
    else $error("word_index out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item.word_index)))
    else $error("result word dropped");
`endif
endmodule
